// ----- rtl/cmst_pkg.sv -----
// shared types, codes and frame tables for the motor status table
package cmst_pkg;

  // input actions
  localparam logic [1:0] ACT_RX    = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_POLL  = 2'd3;

  // host write targets
  localparam logic [2:0] WT_MODE     = 3'd0;
  localparam logic [2:0] WT_VELOCITY = 3'd1;
  localparam logic [2:0] WT_ACCEL    = 3'd2;
  localparam logic [2:0] WT_DECEL    = 3'd3;
  localparam logic [2:0] WT_POSITION = 3'd4;
  localparam logic [2:0] WT_ENABLE   = 3'd5;
  localparam logic [2:0] WT_DISABLE  = 3'd6;
  localparam logic [2:0] WT_STOP     = 3'd7;

  // query targets
  localparam logic [1:0] QT_POSITION = 2'd0;
  localparam logic [1:0] QT_CURRENT  = 2'd1;
  localparam logic [1:0] QT_VELOCITY = 2'd2;
  // unused target: answers zero, sends nothing
  localparam logic [1:0] QT_NONE     = 2'd3;

  // frame kinds in byte 0
  localparam logic [7:0] KIND_WRITE    = 8'h01;
  localparam logic [7:0] KIND_WR_ACK   = 8'h02;
  localparam logic [7:0] KIND_READ     = 8'h03;
  localparam logic [7:0] KIND_READ_RSP = 8'h04;

  // sub-addresses in byte 1
  localparam logic [7:0] SUB_CURRENT  = 8'h05;
  localparam logic [7:0] SUB_VELOCITY = 8'h06;
  localparam logic [7:0] SUB_POSITION = 8'h07;
  localparam logic [7:0] SUB_SET_VEL  = 8'h09;
  localparam logic [7:0] SUB_SET_POS  = 8'h0A;
  localparam logic [7:0] SUB_ACCEL    = 8'h0B;
  localparam logic [7:0] SUB_DECEL    = 8'h0C;
  localparam logic [7:0] SUB_MODE     = 8'h0F;
  localparam logic [7:0] SUB_ENABLE   = 8'h10;
  localparam logic [7:0] SUB_STOP     = 8'h11;
  localparam logic [7:0] SUB_ALARM    = 8'h15;

  // write acknowledge status codes that mean success
  localparam logic [7:0] ACK_OK     = 8'h01;
  localparam logic [7:0] ACK_OK_ALT = 8'h05;

  // mode values on the wire
  localparam logic [31:0] MODE_CODE_POS = 32'd1;
  localparam logic [31:0] MODE_CODE_VEL = 32'd3;
  localparam logic [7:0]  MODE_BYTE_VEL = 8'h03;

  localparam logic [3:0] DLC_MIN  = 4'd2;
  localparam logic [3:0] DLC_MAX  = 4'd8;
  localparam logic [3:0] DLC_WORD = 4'd6;
  localparam logic [3:0] DLC_ACK  = 4'd3;
  localparam logic [3:0] DLC_B5   = 4'd6;

  localparam int POLL_COUNT = 5;
  localparam int POLL_IDX_W = 3;
  localparam logic [POLL_IDX_W-1:0] POLL_LAST = POLL_IDX_W'(POLL_COUNT - 1);

  typedef struct packed {
    logic [1:0]         action;
    logic [7:0]         motor_id;
    logic [2:0]         write_target;
    logic signed [31:0] write_value;
    logic [1:0]         query_target;
    logic [10:0]        rx_id;
    logic               rx_extended;
    logic [3:0]         rx_dlc;
    logic [63:0]        rx_data;
  } in_item_t;

  typedef struct packed {
    logic               tx_valid;
    logic [7:0]         tx_id;
    logic [63:0]        tx_data;
    logic signed [31:0] reply_value;
    logic               reply_known;
    logic               motor_mode;
    logic               motor_enabled;
    logic               write_failed;
    logic               alarm_valid;
    logic [31:0]        alarm_code;
    logic               frame_dropped;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                  capture;
    logic                  exec;
    logic                  step;
    logic [POLL_IDX_W-1:0] poll_idx;
    logic                  last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_poll;
  } dp_status_t;

  function automatic logic [7:0] write_sub(input logic [2:0] target);
    logic [7:0] sub;
    unique case (target)
      WT_MODE:     sub = SUB_MODE;
      WT_VELOCITY: sub = SUB_SET_VEL;
      WT_ACCEL:    sub = SUB_ACCEL;
      WT_DECEL:    sub = SUB_DECEL;
      WT_POSITION: sub = SUB_SET_POS;
      WT_ENABLE:   sub = SUB_ENABLE;
      WT_DISABLE:  sub = SUB_ENABLE;
      WT_STOP:     sub = SUB_STOP;
      default:     sub = SUB_STOP;
    endcase
    return sub;
  endfunction

  function automatic logic [7:0] poll_sub(input logic [POLL_IDX_W-1:0] idx);
    logic [7:0] sub;
    unique case (idx)
      3'd0:    sub = SUB_POSITION;
      3'd1:    sub = SUB_MODE;
      3'd2:    sub = SUB_ENABLE;
      3'd3:    sub = SUB_CURRENT;
      3'd4:    sub = SUB_VELOCITY;
      default: sub = SUB_VELOCITY;
    endcase
    return sub;
  endfunction

  function automatic logic [63:0] make_frame(input logic [7:0] kind, input logic [7:0] sub,
                                             input logic [31:0] value);
    return {kind, sub, value, 16'h0000};
  endfunction

endpackage

// ----- rtl/cmst_ctrl.sv -----
// sequencing state machine: accept, execute and poll result steps
module cmst_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cmst_pkg::dp_status_t status,
  output cmst_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_POLL = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [cmst_pkg::POLL_IDX_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.is_poll) begin
          state_nxt = ST_POLL;
          cnt_nxt   = cmst_pkg::POLL_IDX_W'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POLL: begin
        if (cnt_r == cmst_pkg::POLL_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + cmst_pkg::POLL_IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign cmd.capture  = start && (state_r == ST_IDLE);
  assign cmd.exec     = (state_r == ST_EXEC);
  assign cmd.step     = (state_r == ST_POLL);
  assign cmd.poll_idx = (state_r == ST_POLL) ? cnt_r : '0;
  assign cmd.last     = (state_r == ST_EXEC) ? !status.is_poll
                                             : (cnt_r == cmst_pkg::POLL_LAST);

endmodule

// ----- rtl/cmst_datapath.sv -----
// input register, status table, frame build and decode, result register
module cmst_datapath #(
  parameter int MOTOR_COUNT = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmst_pkg::in_item_t   in_data,
  input  cmst_pkg::dp_cmd_t    cmd,
  output cmst_pkg::dp_status_t status,
  output logic                 out_valid,
  output cmst_pkg::out_item_t  out_data
);

  localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  cmst_pkg::in_item_t  in_r;
  cmst_pkg::out_item_t res;
  cmst_pkg::out_item_t out_data_r;
  logic                out_valid_r;

  logic [31:0] pos_mem [MOTOR_COUNT];
  logic [31:0] cur_mem [MOTOR_COUNT];
  logic [31:0] spd_mem [MOTOR_COUNT];
  logic [31:0] pos_rd_r, cur_rd_r, spd_rd_r;

  // bit4 enable, bit3 mode, bit2 velocity, bit1 current, bit0 position received
  logic [4:0]             stat_mem [MOTOR_COUNT];
  logic [4:0]             stat_rd_r;
  // set once a motor's status entry has been written since reset
  logic [MOTOR_COUNT-1:0] live_r;
  logic [4:0]             cur_stat;

  logic [7:0]       m_sel;
  logic [7:0]       rd_sel;
  logic             in_tab;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] rd_idx;
  logic [2:0]       cur_flags, flags_n;
  logic             cur_mode, mode_n, cur_en, en_n, bits_we;
  logic             pos_we, cur_we, spd_we;

  logic        drop;
  logic [3:0]  dlc_eff;
  logic [7:0]  rx_kind, rx_sub, rx_ack, rx_b5;
  logic [31:0] rx_word;
  logic [31:0] wr_val;
  logic        known;

  assign status.is_poll = (in_r.action == cmst_pkg::ACT_POLL);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
  end

  // stores are read at accept, so the data is ready in the execute cycle
  assign rd_sel = (in_data.action == cmst_pkg::ACT_RX) ? in_data.rx_id[7:0]
                                                       : in_data.motor_id;
  assign rd_idx = rd_sel[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_rd_r  <= pos_mem[rd_idx];
      cur_rd_r  <= cur_mem[rd_idx];
      spd_rd_r  <= spd_mem[rd_idx];
      stat_rd_r <= stat_mem[rd_idx];
    end
    if (pos_we) begin
      pos_mem[idx] <= rx_word;
    end
    if (cur_we) begin
      cur_mem[idx] <= rx_word;
    end
    if (spd_we) begin
      spd_mem[idx] <= rx_word;
    end
    if (bits_we) begin
      stat_mem[idx] <= {en_n, mode_n, flags_n};
    end
  end

  assign m_sel  = (in_r.action == cmst_pkg::ACT_RX) ? in_r.rx_id[7:0] : in_r.motor_id;
  assign in_tab = ({1'b0, m_sel} < 9'(MOTOR_COUNT));
  assign idx    = m_sel[IDX_W-1:0];

  assign cur_stat  = (in_tab && live_r[idx]) ? stat_rd_r : 5'b00000;
  assign cur_flags = cur_stat[2:0];
  assign cur_mode  = cur_stat[3];
  assign cur_en    = cur_stat[4];

  assign drop    = in_r.rx_extended || (in_r.rx_dlc < cmst_pkg::DLC_MIN)
                   || (in_r.rx_id[10:8] != 3'b000);
  assign dlc_eff = (in_r.rx_dlc > cmst_pkg::DLC_MAX) ? cmst_pkg::DLC_MAX : in_r.rx_dlc;
  assign rx_kind = in_r.rx_data[63:56];
  assign rx_sub  = in_r.rx_data[55:48];
  assign rx_ack  = (dlc_eff >= cmst_pkg::DLC_ACK) ? in_r.rx_data[47:40] : 8'h00;
  assign rx_b5   = (dlc_eff >= cmst_pkg::DLC_B5) ? in_r.rx_data[23:16] : 8'h00;
  assign rx_word = (dlc_eff >= cmst_pkg::DLC_WORD) ? in_r.rx_data[47:16] : 32'h0;

  always_comb begin
    res     = '0;
    flags_n = cur_flags;
    mode_n  = cur_mode;
    en_n    = cur_en;
    bits_we = 1'b0;
    pos_we  = 1'b0;
    cur_we  = 1'b0;
    spd_we  = 1'b0;
    wr_val  = in_r.write_value;
    known   = 1'b0;
    unique case (in_r.action)
      cmst_pkg::ACT_RX: begin
        if (drop) begin
          res.frame_dropped = 1'b1;
        end else begin
          if (rx_kind == cmst_pkg::KIND_WR_ACK) begin
            if (rx_ack != cmst_pkg::ACK_OK && rx_ack != cmst_pkg::ACK_OK_ALT) begin
              res.write_failed = 1'b1;
              if (rx_sub == cmst_pkg::SUB_ENABLE) begin
                en_n    = !cur_en;
                bits_we = in_tab;
              end
            end
          end else if (rx_kind == cmst_pkg::KIND_READ_RSP) begin
            if (rx_sub == cmst_pkg::SUB_ALARM) begin
              res.alarm_code  = rx_word;
              res.alarm_valid = (rx_word != 32'h0);
            end else begin
              unique case (rx_sub)
                cmst_pkg::SUB_CURRENT: begin
                  cur_we     = in_tab;
                  flags_n[1] = 1'b1;
                  bits_we    = in_tab;
                end
                cmst_pkg::SUB_VELOCITY: begin
                  spd_we     = in_tab;
                  flags_n[2] = 1'b1;
                  bits_we    = in_tab;
                end
                cmst_pkg::SUB_POSITION: begin
                  pos_we     = in_tab;
                  flags_n[0] = 1'b1;
                  bits_we    = in_tab;
                end
                cmst_pkg::SUB_MODE: begin
                  mode_n  = (rx_b5 == cmst_pkg::MODE_BYTE_VEL);
                  bits_we = in_tab;
                end
                cmst_pkg::SUB_ENABLE: begin
                  en_n    = (rx_b5 != 8'h00);
                  bits_we = in_tab;
                end
                default: begin
                end
              endcase
            end
          end
          res.motor_mode    = in_tab && mode_n;
          res.motor_enabled = in_tab && en_n;
        end
      end
      cmst_pkg::ACT_WRITE: begin
        unique case (in_r.write_target)
          cmst_pkg::WT_MODE: begin
            mode_n  = (in_r.write_value != 32'sd0);
            bits_we = in_tab;
            wr_val  = mode_n ? cmst_pkg::MODE_CODE_VEL : cmst_pkg::MODE_CODE_POS;
          end
          cmst_pkg::WT_ENABLE: begin
            en_n    = 1'b1;
            bits_we = in_tab;
            wr_val  = 32'd1;
          end
          cmst_pkg::WT_DISABLE: begin
            en_n    = 1'b0;
            bits_we = in_tab;
            wr_val  = 32'd0;
          end
          cmst_pkg::WT_STOP: begin
            wr_val = 32'd1;
          end
          default: begin
          end
        endcase
        res.tx_valid      = 1'b1;
        res.tx_id         = in_r.motor_id;
        res.tx_data       = cmst_pkg::make_frame(cmst_pkg::KIND_WRITE,
                                                 cmst_pkg::write_sub(in_r.write_target),
                                                 wr_val);
        res.motor_mode    = in_tab && mode_n;
        res.motor_enabled = in_tab && en_n;
      end
      cmst_pkg::ACT_QUERY: begin
        unique case (in_r.query_target)
          cmst_pkg::QT_POSITION: begin
            known           = cur_flags[0];
            res.reply_value = pos_rd_r;
            res.tx_data     = cmst_pkg::make_frame(cmst_pkg::KIND_READ,
                                                   cmst_pkg::SUB_POSITION, 32'h0);
          end
          cmst_pkg::QT_CURRENT: begin
            known           = cur_flags[1];
            res.reply_value = {{16{cur_rd_r[15]}}, cur_rd_r[15:0]};
            res.tx_data     = cmst_pkg::make_frame(cmst_pkg::KIND_READ,
                                                   cmst_pkg::SUB_CURRENT, 32'h0);
          end
          cmst_pkg::QT_VELOCITY: begin
            known           = cur_flags[2];
            res.reply_value = {{16{spd_rd_r[15]}}, spd_rd_r[15:0]};
            res.tx_data     = cmst_pkg::make_frame(cmst_pkg::KIND_READ,
                                                   cmst_pkg::SUB_VELOCITY, 32'h0);
          end
          default: begin
          end
        endcase
        // unknown value: answer zero and, for any target but QT_NONE, send the read request instead
        res.tx_valid = !known && (in_r.query_target != cmst_pkg::QT_NONE);
        if (!res.tx_valid) begin
          res.tx_data = '0;
        end
        res.tx_id         = res.tx_valid ? in_r.motor_id : 8'h00;
        if (!known) begin
          res.reply_value = '0;
        end
        res.reply_known   = known;
        res.motor_mode    = cur_mode;
        res.motor_enabled = cur_en;
      end
      cmst_pkg::ACT_POLL: begin
        res.tx_valid      = 1'b1;
        res.tx_id         = in_r.motor_id;
        res.tx_data       = cmst_pkg::make_frame(cmst_pkg::KIND_READ,
                                                 cmst_pkg::poll_sub(cmd.poll_idx), 32'h0);
        res.motor_mode    = cur_mode;
        res.motor_enabled = cur_en;
      end
      default: begin
      end
    endcase
    res.last = cmd.last;
    if (!cmd.exec) begin
      bits_we = 1'b0;
      pos_we  = 1'b0;
      cur_we  = 1'b0;
      spd_we  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else if (bits_we) begin
      live_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec || cmd.step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.step) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/can_motor_status_table_core.sv -----
// top level of the per-motor status table with command frame build and reply decode
//
// usage:
//   drive in_data and raise start; the item transfers at a rising edge with start
//   high and busy low. in_data.action selects received frame, host write, cached
//   query or poll.
//   results leave on out_data, each valid for exactly one cycle while out_valid is
//   high; out_data.last marks the final result of an item. the receiver cannot
//   stall, so results never wait.
//   the first result passes the execute cycle and then the result register before it
//   reaches the ports. frame, write and query items pass the execute state and then
//   idle, where the next item can be accepted; the stores read at accept are used and
//   written back in the execute state. a poll passes the execute state and then the
//   poll state, its five read frames leaving on consecutive cycles.
//   busy is high from the accepting edge until the last result is registered.
//   a new item can be accepted while the previous result is still on the ports.
//   reset: the state machine and one written-since-reset bit per motor clear; status
//   entries and value stores read as zero until written, no pass.
module can_motor_status_table_core #(
  parameter int MOTOR_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  cmst_pkg::in_item_t  in_data,
  output logic                out_valid,
  output cmst_pkg::out_item_t out_data
);

  cmst_pkg::dp_cmd_t    cmd;
  cmst_pkg::dp_status_t status;

  cmst_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  cmst_datapath #(
    .MOTOR_COUNT (MOTOR_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a transfer always leaves the block busy for its execute cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after input transfer");

  // an item's final result is never followed directly by another result
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result directly after final result");

  // poll results come back to back until the last one
  a_poll_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("gap inside a multi-result item");

endmodule
